>>> design/wavg_pkg.sv
// ----------------------------------------------------------------------------
// wavg_pkg
// Shared types and constants for the wave header parser with gain.
// ----------------------------------------------------------------------------
package wavg_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] REG_CLIP_LENGTH = 2'd0;
    localparam logic [1:0] REG_VOLUME      = 2'd1;
    localparam logic [1:0] REG_CODEC_ATT   = 2'd2;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] MIN_CLIP_LENGTH = 32'd44;
    localparam logic [31:0] MIN_FMT_SIZE    = 32'd16;
    localparam logic [15:0] FORMAT_PCM      = 16'd1;
    localparam logic [15:0] PCM_BITS        = 16'd16;
    localparam logic [6:0]  VOLUME_FULL     = 7'd100;
    localparam logic [17:0] GAIN_RECIP      = 18'd167773;

    localparam logic [31:0] RESET_CLIP_LENGTH = 32'd0;
    localparam logic [6:0]  RESET_VOLUME      = 7'd70;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] raw_sample;
        logic [31:0] fmt_rate;
        logic [15:0] channel_count;
        logic        end_of_clip;
    } wavg_item_t;

endpackage

>>> design/wav_header_parser_with_gain_unit.sv
// ----------------------------------------------------------------------------
// wav_header_parser_with_gain_unit
// RIFF/WAVE PCM16 clip parser with software volume gain.
// ----------------------------------------------------------------------------
// Takes one clip byte per cycle and gives at most one result per byte: a format
// report, a scaled 16-bit sample, or a rejection. The parser runs one byte per
// cycle; its results pass a queue of QUEUE_DEPTH entries to a gain stage with
// two multipliers and an output register; each result is written into the
// queue and then into the output register. Input stalls only when the queue is
// full. After the end of the clip or a rejection further bytes are taken and
// ignored until reset. The user makes configuration writes while idle; the block does not enforce it.
module wav_header_parser_with_gain_unit
    import wavg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         clip_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic signed [15:0] sample,
    output logic [31:0]        fmt_rate,
    output logic [15:0]        channel_count,
    output logic               end_of_clip,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [31:0] clip_length_reg;
    logic [6:0]  volume_reg;
    logic        codec_att_reg;

    logic        q_full;
    logic        f_push;
    wavg_item_t  f_item;
    logic        q_valid;
    logic        q_pop;
    wavg_item_t  q_item;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_length_reg <= RESET_CLIP_LENGTH;
            volume_reg      <= RESET_VOLUME;
            codec_att_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CLIP_LENGTH: clip_length_reg <= cfg_data;
                REG_VOLUME:      volume_reg      <= cfg_data[6:0];
                REG_CODEC_ATT:   codec_att_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    wavg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_fire   (in_valid && in_ready),
        .clip_byte   (clip_byte),
        .clip_length (clip_length_reg),
        .push        (f_push),
        .item        (f_item)
    );

    wavg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    wavg_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .volume_percent   (volume_reg),
        .codec_attenuates (codec_att_reg),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .sample           (sample),
        .fmt_rate         (fmt_rate),
        .channel_count    (channel_count),
        .end_of_clip      (end_of_clip)
    );

endmodule

>>> design/wavg_front.sv
// ----------------------------------------------------------------------------
// wavg_front
// Byte parser: tag checks, chunk walk, fmt capture and data framing.
// ----------------------------------------------------------------------------
module wavg_front
    import wavg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_fire,
    input  logic [7:0]  clip_byte,
    input  logic [31:0] clip_length,
    output logic        push,
    output wavg_item_t  item
);

    typedef enum logic [11:0] {
        PH_RIFF     = 12'b0000_0000_0001,
        PH_RSIZE    = 12'b0000_0000_0010,
        PH_WAVE     = 12'b0000_0000_0100,
        PH_ID       = 12'b0000_0000_1000,
        PH_SZ_OTHER = 12'b0000_0001_0000,
        PH_SZ_FMT   = 12'b0000_0010_0000,
        PH_SZ_DATA  = 12'b0000_0100_0000,
        PH_SKIP     = 12'b0000_1000_0000,
        PH_FMT      = 12'b0001_0000_0000,
        PH_DATA     = 12'b0010_0000_0000,
        PH_DONE     = 12'b0100_0000_0000,
        PH_REJ      = 12'b1000_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] remain_reg, remain_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [15:0] fmt_code_reg, fmt_code_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [7:0]  low_reg, low_next;

    logic [31:0] shifted;
    logic [31:0] remain_dec;
    logic [32:0] header_end;
    logic [32:0] chunk_end;
    logic        header_fits;

    assign shifted     = {clip_byte, shift_reg[31:8]};
    assign remain_dec  = remain_reg - 32'd1;
    assign header_end  = {1'b0, pos_reg} + 33'd9;
    assign chunk_end   = {1'b0, pos_reg} + 33'd1 + {1'b0, shifted};
    assign header_fits = header_end <= {1'b0, clip_length};

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        remain_next   = remain_reg;
        fmt_seen_next = fmt_seen_reg;
        fmt_code_next = fmt_code_reg;
        chans_next    = chans_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        low_next      = low_reg;
        push          = 1'b0;
        item          = '0;
        if (byte_fire)
        begin
            pos_next = pos_reg + 32'd1;
            unique case (phase_reg)
                PH_RIFF:
                begin
                    if (pos_reg == 32'd0 && clip_length < MIN_CLIP_LENGTH)
                    begin
                        push      = 1'b1;
                        phase_next = PH_REJ;
                    end
                    else
                    begin
                        shift_next = shifted;
                        if (pos_reg >= 32'd3)
                        begin
                            if (shifted != TAG_RIFF)
                            begin
                                push       = 1'b1;
                                phase_next = PH_REJ;
                            end
                            else
                            begin
                                phase_next = PH_RSIZE;
                            end
                        end
                    end
                end
                PH_RSIZE:
                begin
                    if (pos_reg >= 32'd7)
                    begin
                        phase_next = PH_WAVE;
                    end
                end
                PH_WAVE:
                begin
                    shift_next = shifted;
                    if (pos_reg >= 32'd11)
                    begin
                        if (shifted != TAG_WAVE || !header_fits)
                        begin
                            push       = 1'b1;
                            phase_next = PH_REJ;
                        end
                        else
                        begin
                            phase_next  = PH_ID;
                            remain_next = 32'd4;
                        end
                    end
                end
                PH_ID:
                begin
                    shift_next  = shifted;
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        remain_next = 32'd4;
                        if (shifted == TAG_FMT)
                        begin
                            phase_next = PH_SZ_FMT;
                        end
                        else if (shifted == TAG_DATA)
                        begin
                            phase_next = PH_SZ_DATA;
                        end
                        else
                        begin
                            phase_next = PH_SZ_OTHER;
                        end
                    end
                end
                PH_SZ_OTHER, PH_SZ_FMT, PH_SZ_DATA:
                begin
                    shift_next  = shifted;
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        if (chunk_end > {1'b0, clip_length})
                        begin
                            push       = 1'b1;
                            phase_next = PH_REJ;
                        end
                        else if (phase_reg == PH_SZ_FMT && shifted >= MIN_FMT_SIZE)
                        begin
                            fmt_seen_next = 1'b1;
                            phase_next    = PH_FMT;
                            remain_next   = shifted;
                            shift_next    = '0;
                        end
                        else if (phase_reg == PH_SZ_DATA && fmt_seen_reg)
                        begin
                            push = 1'b1;
                            if (fmt_code_reg != FORMAT_PCM || bits_reg != PCM_BITS)
                            begin
                                phase_next = PH_REJ;
                            end
                            else
                            begin
                                item.kind          = KIND_FORMAT;
                                item.fmt_rate      = rate_reg;
                                item.channel_count = chans_reg;
                                item.end_of_clip   = shifted < 32'd2;
                                remain_next        = shifted;
                                shift_next         = '0;
                                phase_next         = (shifted < 32'd2) ? PH_DONE : PH_DATA;
                            end
                        end
                        else if (shifted == 32'd0)
                        begin
                            if (!header_fits)
                            begin
                                push       = 1'b1;
                                phase_next = PH_REJ;
                            end
                            else
                            begin
                                phase_next  = PH_ID;
                                remain_next = 32'd4;
                            end
                        end
                        else
                        begin
                            phase_next  = PH_SKIP;
                            remain_next = shifted;
                        end
                    end
                end
                PH_SKIP, PH_FMT:
                begin
                    if (phase_reg == PH_FMT)
                    begin
                        case (shift_reg[4:0])
                            5'd0:  fmt_code_next[7:0]  = clip_byte;
                            5'd1:  fmt_code_next[15:8] = clip_byte;
                            5'd2:  chans_next[7:0]     = clip_byte;
                            5'd3:  chans_next[15:8]    = clip_byte;
                            5'd4:  rate_next[7:0]      = clip_byte;
                            5'd5:  rate_next[15:8]     = clip_byte;
                            5'd6:  rate_next[23:16]    = clip_byte;
                            5'd7:  rate_next[31:24]    = clip_byte;
                            5'd14: bits_next[7:0]      = clip_byte;
                            5'd15: bits_next[15:8]     = clip_byte;
                            default: ;
                        endcase
                        if (shift_reg < 32'd16)
                        begin
                            shift_next = shift_reg + 32'd1;
                        end
                    end
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        if (!header_fits)
                        begin
                            push       = 1'b1;
                            phase_next = PH_REJ;
                        end
                        else
                        begin
                            phase_next  = PH_ID;
                            remain_next = 32'd4;
                        end
                    end
                end
                PH_DATA:
                begin
                    remain_next = remain_dec;
                    if (!shift_reg[0])
                    begin
                        low_next   = clip_byte;
                        shift_next = 32'd1;
                        if (remain_dec == 32'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        shift_next       = '0;
                        push             = 1'b1;
                        item.kind        = KIND_SAMPLE;
                        item.raw_sample  = {clip_byte, low_reg};
                        item.end_of_clip = remain_dec < 32'd2;
                        if (remain_dec < 32'd2)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_DONE, PH_REJ:
                begin
                    pos_next = pos_reg;
                end
                default:
                begin
                    phase_next = PH_REJ;
                end
            endcase
            if (push && phase_next == PH_REJ)
            begin
                item             = '0;
                item.kind        = KIND_REJECT;
                item.end_of_clip = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            pos_reg      <= '0;
            shift_reg    <= '0;
            remain_reg   <= '0;
            fmt_seen_reg <= 1'b0;
            fmt_code_reg <= '0;
            chans_reg    <= '0;
            rate_reg     <= '0;
            bits_reg     <= '0;
            low_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            remain_reg   <= remain_next;
            fmt_seen_reg <= fmt_seen_next;
            fmt_code_reg <= fmt_code_next;
            chans_reg    <= chans_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            low_reg      <= low_next;
        end
    end

endmodule

>>> design/wavg_queue.sv
// ----------------------------------------------------------------------------
// wavg_queue
// Small request queue between the parser and the gain stage.
// ----------------------------------------------------------------------------
module wavg_queue
    import wavg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  wavg_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output wavg_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wavg_item_t       slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = count_reg == FULL_CNT;
    assign pop_valid = count_reg != '0;
    assign pop_item  = slots[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/wavg_back.sv
// ----------------------------------------------------------------------------
// wavg_back
// Gain stage and output register for parsed results.
// ----------------------------------------------------------------------------
module wavg_back
    import wavg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [6:0]   volume_percent,
    input  logic         codec_attenuates,
    input  logic         q_valid,
    input  wavg_item_t   q_item,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   kind,
    output logic signed [15:0] sample,
    output logic [31:0]  fmt_rate,
    output logic [15:0]  channel_count,
    output logic         end_of_clip
);

    logic [24:0]        gain_prod;
    logic [7:0]         gain_reg;
    logic               bypass_reg;
    logic signed [24:0] scaled_prod;
    logic [15:0]        scaled;
    logic               valid_reg;

    // gain = floor(volume * 256 / 100) by reciprocal multiply
    assign gain_prod   = 25'(volume_percent) * 25'(GAIN_RECIP);
    assign scaled_prod = 25'($signed(q_item.raw_sample)) * $signed({17'd0, gain_reg});
    assign scaled      = bypass_reg ? q_item.raw_sample : scaled_prod[23:8];

    assign q_pop     = q_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= '0;
            bypass_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            gain_reg   <= gain_prod[23:16];
            bypass_reg <= codec_attenuates || (volume_percent >= VOLUME_FULL);
            if (q_pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind          <= q_item.kind;
            sample        <= $signed(scaled);
            fmt_rate      <= q_item.fmt_rate;
            channel_count <= q_item.channel_count;
            end_of_clip   <= q_item.end_of_clip;
        end
    end

endmodule

>>> design/wavg_checker.sv
// ----------------------------------------------------------------------------
// wavg_checker
// Port-level checks on the result channel of the parser.
// ----------------------------------------------------------------------------
module wavg_checker
    import wavg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         kind,
    input logic signed [15:0] sample,
    input logic [31:0]        fmt_rate,
    input logic [15:0]        channel_count,
    input logic               end_of_clip
);

    // stalled request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(sample)
            && $stable(end_of_clip))
        else $error("result changed while stalled");

    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_REJECT |-> end_of_clip && sample == 16'sd0
            && fmt_rate == 32'd0 && channel_count == 16'd0)
        else $error("rejection carries payload");

    a_sample_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SAMPLE |-> fmt_rate == 32'd0 && channel_count == 16'd0)
        else $error("sample carries format fields");

    a_format_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FORMAT |-> sample == 16'sd0)
        else $error("format report carries a sample");

endmodule

bind wav_header_parser_with_gain_unit wavg_checker u_wavg_checker (.*);
